[rtl/bitmap_sort_engine_core_assert.svh]
// ----------------------------------------------------------------------------
// bitmap_sort_engine_core_assert.svh
// Assertion macros used by the bitmap sort engine datapath.
// ----------------------------------------------------------------------------
`ifndef BITMAP_SORT_ENGINE_CORE_ASSERT_SVH
`define BITMAP_SORT_ENGINE_CORE_ASSERT_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define BSE_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("bse: same-cycle check failed");

// next-cycle implication
`define BSE_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("bse: next-cycle check failed");

`endif

[rtl/bse_pkg.sv]
// ----------------------------------------------------------------------------
// bse_pkg
// Widths, types and command codes of the bitmap sort engine.
// ----------------------------------------------------------------------------
package bse_pkg;

  localparam int KEY_BITS   = 16;
  localparam int WORD_BITS  = 8;
  localparam int OFF_BITS   = $clog2(WORD_BITS);
  localparam int ADDR_BITS  = KEY_BITS - OFF_BITS;
  localparam int WORD_COUNT = 1 << ADDR_BITS;

  typedef logic [KEY_BITS-1:0]  key_t;
  typedef logic [WORD_BITS-1:0] word_t;
  typedef logic [OFF_BITS-1:0]  off_t;
  typedef logic [ADDR_BITS-1:0] addr_t;
  typedef logic [KEY_BITS:0]    count_t;

  // top bit of a word holds the lowest key of that word
  localparam word_t TOP_BIT = word_t'(1) << (WORD_BITS - 1);

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_FETCH  = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INSERT,
    ST_SCAN
  } state_e;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_INS_RD,
    CMD_INS_WR,
    CMD_FET_RD,
    CMD_FET_CHK,
    CMD_EMPTY
  } cmd_e;

  typedef struct packed {
    cmd_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic empty;
    logic word_hit;
  } dp_stat_t;

  function automatic word_t bit_for(off_t off);
    return TOP_BIT >> off;
  endfunction

  // offset of the first set bit counted from the top
  function automatic off_t first_offset(word_t w);
    off_t off;
    off = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[WORD_BITS-1-i]) begin
        off = off_t'(i);
      end
    end
    return off;
  endfunction

endpackage

[rtl/bitmap_sort_engine_core.sv]
// Insert: read, then write-back; strobe as the next word can be accepted.
// Fetch on an empty store: result in the cycle after accept, busy stays low.
// Fetch with keys present: cursor word read, then checked in ST_SCAN, reading
// on past zero words, one bitmap word read per cycle on the single store port.
// Reset: clearing pass over all 8192 store words with busy high.
// Results are strobed for one cycle; the receiver cannot stall.
// ----------------------------------------------------------------------------
// bitmap_sort_engine_core
// Top level: sorted set of 16-bit keys, insert and fetch-smallest commands.
// ----------------------------------------------------------------------------
module bitmap_sort_engine_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic          operation_i,
  input  bse_pkg::key_t key_value_i,
  output logic          result_valid_o,
  output bse_pkg::key_t sorted_key_o,
  output logic          found_o
);

  bse_pkg::dp_cmd_t  cmd;
  bse_pkg::dp_stat_t stat;

  bse_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .operation_i (operation_i),
    .stat_i      (stat),
    .cmd_o       (cmd),
    .busy        (busy)
  );

  bse_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .key_value_i    (key_value_i),
    .cmd_i          (cmd),
    .stat_o         (stat),
    .result_valid_o (result_valid_o),
    .sorted_key_o   (sorted_key_o),
    .found_o        (found_o)
  );

endmodule

[rtl/bse_ctrl.sv]
// ----------------------------------------------------------------------------
// bse_ctrl
// Sequencer of the bitmap sort engine: clear pass, insert, fetch scan.
// ----------------------------------------------------------------------------
module bse_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              operation_i,
  input  bse_pkg::dp_stat_t stat_i,
  output bse_pkg::dp_cmd_t  cmd_o,
  output logic              busy
);

  bse_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bse_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    cmd_o.op  = bse_pkg::CMD_NONE;
    busy      = 1'b1;
    case (state_q)
      bse_pkg::ST_CLEAR: begin
        cmd_o.op = bse_pkg::CMD_CLEAR;
        if (stat_i.clr_last) begin
          state_d = bse_pkg::ST_IDLE;
        end
      end
      bse_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (operation_i == bse_pkg::OP_INSERT) begin
            cmd_o.op = bse_pkg::CMD_INS_RD;
            state_d  = bse_pkg::ST_INSERT;
          end else if (stat_i.empty) begin
            // nothing stored: answer at once, no scan
            cmd_o.op = bse_pkg::CMD_EMPTY;
          end else begin
            cmd_o.op = bse_pkg::CMD_FET_RD;
            state_d  = bse_pkg::ST_SCAN;
          end
        end
      end
      bse_pkg::ST_INSERT: begin
        cmd_o.op = bse_pkg::CMD_INS_WR;
        state_d  = bse_pkg::ST_IDLE;
      end
      bse_pkg::ST_SCAN: begin
        cmd_o.op = bse_pkg::CMD_FET_CHK;
        if (stat_i.word_hit) begin
          state_d = bse_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = bse_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

[rtl/bse_datapath.sv]
// ----------------------------------------------------------------------------
// bse_datapath
// Bitmap store, scan cursor, key count and result registers.
// ----------------------------------------------------------------------------
`include "bitmap_sort_engine_core_assert.svh"

module bse_datapath (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bse_pkg::key_t     key_value_i,
  input  bse_pkg::dp_cmd_t  cmd_i,
  output bse_pkg::dp_stat_t stat_o,
  output logic              result_valid_o,
  output bse_pkg::key_t     sorted_key_o,
  output logic              found_o
);

  bse_pkg::word_t mem [bse_pkg::WORD_COUNT];

  bse_pkg::word_t  rdata_q;
  bse_pkg::addr_t  scan_addr_q, scan_addr_d;
  bse_pkg::addr_t  cursor_q, cursor_d;
  bse_pkg::count_t count_q, count_d;
  bse_pkg::key_t   key_q, key_d;
  logic            done_q, done_d;
  bse_pkg::key_t   sorted_key_q, sorted_key_d;
  logic            found_q, found_d;

  logic           mem_we, mem_re;
  bse_pkg::addr_t mem_waddr, mem_raddr;
  bse_pkg::word_t mem_wdata;

  bse_pkg::addr_t key_word;
  bse_pkg::word_t key_bit;
  bse_pkg::off_t  hit_off;
  logic           hit;

  assign key_word = key_q[bse_pkg::KEY_BITS-1:bse_pkg::OFF_BITS];
  assign key_bit  = bse_pkg::bit_for(key_q[bse_pkg::OFF_BITS-1:0]);
  assign hit      = (rdata_q != '0);
  assign hit_off  = bse_pkg::first_offset(rdata_q);

  always_comb begin
    mem_we       = 1'b0;
    mem_re       = 1'b0;
    mem_waddr    = scan_addr_q;
    mem_raddr    = scan_addr_q;
    mem_wdata    = '0;
    scan_addr_d  = scan_addr_q;
    cursor_d     = cursor_q;
    count_d      = count_q;
    key_d        = key_q;
    done_d       = 1'b0;
    sorted_key_d = '0;
    found_d      = 1'b0;
    case (cmd_i.op)
      bse_pkg::CMD_CLEAR: begin
        mem_we      = 1'b1;
        scan_addr_d = scan_addr_q + bse_pkg::addr_t'(1);
      end
      bse_pkg::CMD_INS_RD: begin
        mem_re    = 1'b1;
        mem_raddr = key_value_i[bse_pkg::KEY_BITS-1:bse_pkg::OFF_BITS];
        key_d     = key_value_i;
      end
      bse_pkg::CMD_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = key_word;
        mem_wdata = rdata_q | key_bit;
        if ((rdata_q & key_bit) == '0) begin
          count_d = count_q + bse_pkg::count_t'(1);
        end
        if (key_word < cursor_q) begin
          cursor_d = key_word;
        end
        done_d = 1'b1;
      end
      bse_pkg::CMD_FET_RD: begin
        mem_re      = 1'b1;
        mem_raddr   = cursor_q;
        scan_addr_d = cursor_q;
      end
      bse_pkg::CMD_FET_CHK: begin
        if (hit) begin
          mem_we       = 1'b1;
          mem_wdata    = rdata_q & ~bse_pkg::bit_for(hit_off);
          cursor_d     = scan_addr_q;
          count_d      = count_q - bse_pkg::count_t'(1);
          done_d       = 1'b1;
          found_d      = 1'b1;
          sorted_key_d = {scan_addr_q, hit_off};
        end else begin
          // words below the cursor are zero and count is nonzero, so this ends
          mem_re      = 1'b1;
          mem_raddr   = scan_addr_q + bse_pkg::addr_t'(1);
          scan_addr_d = scan_addr_q + bse_pkg::addr_t'(1);
        end
      end
      bse_pkg::CMD_EMPTY: begin
        done_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rdata_q <= mem[mem_raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_addr_q <= '0;
      cursor_q    <= '0;
      count_q     <= '0;
      done_q      <= 1'b0;
    end else begin
      scan_addr_q <= scan_addr_d;
      cursor_q    <= cursor_d;
      count_q     <= count_d;
      done_q      <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    sorted_key_q <= sorted_key_d;
    found_q      <= found_d;
  end

  assign stat_o.clr_last = (scan_addr_q == '1);
  assign stat_o.empty    = (count_q == '0);
  assign stat_o.word_hit = hit;

  assign result_valid_o = done_q;
  assign sorted_key_o   = sorted_key_q;
  assign found_o        = found_q;

  `BSE_ASSERT_IMP(a_port_excl, mem_we, !mem_re)
  `BSE_ASSERT_IMP(a_scan_nonempty, cmd_i.op == bse_pkg::CMD_FET_CHK, count_q != '0)
  `BSE_ASSERT_NXT(a_ins_result, cmd_i.op == bse_pkg::CMD_INS_WR, done_q && !found_q)
  `BSE_ASSERT_NXT(a_fetch_hit, (cmd_i.op == bse_pkg::CMD_FET_CHK) && hit,
                  done_q && found_q && (count_q == $past(count_q) - bse_pkg::count_t'(1)))

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Sends insert and fetch words to the bitmap sort engine and checks each
// strobed result against a software copy of the key set and scan cursor.
// ----------------------------------------------------------------------------
module testbench;

  localparam int unsigned CYCLE_LIMIT  = 60_000_000;
  localparam int unsigned RANDOM_WORDS = 1850;

  typedef struct {
    bse_pkg::key_t key;
    logic          found;
  } fetch_result_t;

  class key_set_board;
    bse_pkg::word_t  bitmap [bse_pkg::WORD_COUNT];
    bse_pkg::addr_t  cursor;
    int unsigned     keys_held;
    int unsigned     mismatches;
    fetch_result_t   due_words [$];

    function new();
      foreach (bitmap[i]) bitmap[i] = '0;
      cursor     = '0;
      keys_held  = 0;
      mismatches = 0;
    endfunction

    // updates the key set and returns the result the engine owes for this word
    function fetch_result_t predict_word(logic op, bse_pkg::key_t key);
      fetch_result_t  res;
      bse_pkg::addr_t slot;
      bse_pkg::word_t mask;
      res.key   = '0;
      res.found = 1'b0;
      if (op == bse_pkg::OP_INSERT) begin
        slot = key[bse_pkg::KEY_BITS-1:bse_pkg::OFF_BITS];
        mask = bse_pkg::TOP_BIT >> key[bse_pkg::OFF_BITS-1:0];
        if ((bitmap[slot] & mask) == '0) keys_held++;
        bitmap[slot] |= mask;
        if (slot < cursor) cursor = slot;
      end else if (keys_held != 0) begin
        // lowest key of an entry sits in its top bit
        for (int w = int'(cursor); w < bse_pkg::WORD_COUNT && !res.found; w++) begin
          for (int b = 0; b < bse_pkg::WORD_BITS && !res.found; b++) begin
            mask = bse_pkg::TOP_BIT >> b;
            if ((bitmap[w] & mask) != '0) begin
              bitmap[w] &= ~mask;
              keys_held--;
              cursor    = bse_pkg::addr_t'(w);
              res.key   = {bse_pkg::addr_t'(w), bse_pkg::off_t'(b)};
              res.found = 1'b1;
            end
          end
        end
      end
      return res;
    endfunction

    function void note_word(logic op, bse_pkg::key_t key);
      due_words = {due_words, predict_word(op, key)};
    endfunction

    task flag_mismatch(string msg);
      $display("mismatch: %s", msg);
      mismatches++;
    endtask

    task check_word(bse_pkg::key_t key, logic found);
      fetch_result_t want;
      if (due_words.size() == 0) begin
        flag_mismatch($sformatf("result key %h found %b with nothing outstanding",
                                key, found));
      end else begin
        want = due_words.pop_front();
        if (key !== want.key)
          flag_mismatch($sformatf("sorted_key %h, expected %h", key, want.key));
        if (found !== want.found)
          flag_mismatch($sformatf("found %b, expected %b (key %h)", found, want.found,
                                  want.key));
      end
    endtask
  endclass

  logic          clk_i = 1'b0;
  logic          rst_ni;
  logic          start;
  logic          busy;
  logic          operation_i;
  bse_pkg::key_t key_value_i;
  logic          result_valid_o;
  bse_pkg::key_t sorted_key_o;
  logic          found_o;

  key_set_board board;
  bit           idle_ok = 1'b1;
  int unsigned  words_sent = 0;
  int unsigned  cycles = 0;

  bitmap_sort_engine_core u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .operation_i    (operation_i),
    .key_value_i    (key_value_i),
    .result_valid_o (result_valid_o),
    .sorted_key_o   (sorted_key_o),
    .found_o        (found_o)
  );

  always #1 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) board.check_word(sorted_key_o, found_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  // one word per call; an optional gap with start low and junk on the fields
  task automatic send_word(logic op, bse_pkg::key_t key);
    int unsigned gap;
    @(negedge clk_i);
    if (idle_ok && $urandom_range(0, 99) < 10) begin
      gap = $urandom_range(1, 4);
      start       <= 1'b0;
      operation_i <= 1'($urandom);
      key_value_i <= bse_pkg::key_t'($urandom);
      repeat (gap - 1) begin
        @(negedge clk_i);
        operation_i <= 1'($urandom);
        key_value_i <= bse_pkg::key_t'($urandom);
      end
      @(negedge clk_i);
    end
    start       <= 1'b1;
    operation_i <= op;
    key_value_i <= key;
    // busy only moves on a rising edge, so it is stable at the falling edge
    while (busy) @(negedge clk_i);
    @(posedge clk_i);
    board.note_word(op, key);
    words_sent++;
  endtask

  task automatic hold_until_drained();
    @(negedge clk_i);
    start <= 1'b0;
    while (board.due_words.size() != 0) @(negedge clk_i);
  endtask

  // well-formed batch: inserts in one key window, then fetches to empty;
  // a broken batch stops early and slips inserts into the drain
  task automatic fill_and_drain();
    int unsigned   n, span, drain;
    bse_pkg::key_t base, k;
    bit            wide, broken;
    n      = $urandom_range(1, 12);
    wide   = ($urandom_range(0, 11) == 0);
    span   = wide ? 65535 : $urandom_range(8, 160);
    base   = wide ? bse_pkg::key_t'(0) : bse_pkg::key_t'($urandom_range(0, 65535 - span));
    broken = ($urandom_range(0, 7) == 0);
    k      = base;
    for (int i = 0; i < n; i++) begin
      if (i == 0 || $urandom_range(0, 5) != 0)
        k = base + bse_pkg::key_t'($urandom_range(0, span));
      send_word(bse_pkg::OP_INSERT, k);
    end
    drain = broken ? $urandom_range(0, board.keys_held)
                   : board.keys_held + $urandom_range(0, 2);
    for (int i = 0; i < drain; i++) begin
      if (broken && $urandom_range(0, 3) == 0)
        send_word(bse_pkg::OP_INSERT, base + bse_pkg::key_t'($urandom_range(0, span)));
      else
        send_word(bse_pkg::OP_FETCH, bse_pkg::key_t'($urandom));
    end
  endtask

  task automatic noise_burst();
    bse_pkg::key_t base;
    base = bse_pkg::key_t'($urandom_range(0, 65535 - 255));
    repeat ($urandom_range(4, 10)) begin
      if ($urandom_range(0, 15) == 0)
        send_word(1'($urandom), bse_pkg::key_t'($urandom));
      else
        send_word(1'($urandom), base + bse_pkg::key_t'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    int unsigned first_random;
    rst_ni      = 1'b0;
    start       = 1'b0;
    operation_i = bse_pkg::OP_INSERT;
    key_value_i = '0;
    board       = new();
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    send_word(bse_pkg::OP_FETCH,  16'hFFFF);  // empty store
    send_word(bse_pkg::OP_INSERT, 16'hFFFF);
    send_word(bse_pkg::OP_INSERT, 16'h0000);
    send_word(bse_pkg::OP_INSERT, 16'h0000);  // duplicate
    send_word(bse_pkg::OP_FETCH,  16'h0000);
    send_word(bse_pkg::OP_FETCH,  16'h5555);  // scans the whole store up to the top key
    send_word(bse_pkg::OP_FETCH,  16'hAAAA);  // empty, cursor parked at the top
    send_word(bse_pkg::OP_INSERT, 16'h8000);  // below cursor
    send_word(bse_pkg::OP_INSERT, 16'h1235);
    send_word(bse_pkg::OP_INSERT, 16'h1230);
    send_word(bse_pkg::OP_INSERT, 16'h1237);
    send_word(bse_pkg::OP_INSERT, 16'h5555);
    send_word(bse_pkg::OP_INSERT, 16'hAAAA);
    send_word(bse_pkg::OP_INSERT, 16'h7FFF);
    repeat (8) send_word(bse_pkg::OP_FETCH, bse_pkg::key_t'($urandom));
    hold_until_drained();

    first_random = words_sent;
    while (words_sent - first_random < RANDOM_WORDS) begin
      // a long stretch with no random idle gaps between sent words
      idle_ok = !(words_sent - first_random >= 700 && words_sent - first_random < 1100);
      if ($urandom_range(0, 5) == 0) noise_burst();
      else fill_and_drain();
      if ($urandom_range(0, 19) == 0) hold_until_drained();
    end

    hold_until_drained();
    repeat (20) @(posedge clk_i);
    if (board.mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/bse_pkg.sv
rtl/bse_ctrl.sv
rtl/bse_datapath.sv
rtl/bitmap_sort_engine_core.sv
tb/sv/testbench.sv
